// File: rtl/core/tach_pkg.sv
package tach_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned RES_W = 12;

   typedef enum logic [1:0] {
      REQ_CAPTURE  = 2'd0,
      REQ_LIVE     = 2'd1,
      REQ_OVERRIDE = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CH_NONE  = 2'd0,
      CH_LEFT  = 2'd1,
      CH_RIGHT = 2'd2,
      CH_BOTH  = 2'd3
   } chan_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic commit;
   } tach_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } tach_status_type;

endpackage

// File: rtl/core/tach_ctrl.sv
module tach_ctrl
   import tach_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  tach_status_type status,
   output tach_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PREP  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign commit     = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = status.need_div ? ST_DIV : ST_WRITE;
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      cmd.load     = req_tvalid && (state_ff == ST_IDLE);
      cmd.prep     = (state_ff == ST_PREP);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.commit   = commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/tach_dp.sv
module tach_dp
   import tach_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = 1000000
) (
   input  logic                clock,
   input  logic                reset,
   input  tach_cmd_type        cmd,
   output tach_status_type     status,
   input  logic [3:0]          req_tuser,
   input  logic [63:0]         req_tdata,
   input  logic                csr_write,
   input  logic [RES_W-1:0]    csr_data,
   output logic [95:0]         rsp_tdata,
   output logic                rsp_zero
);

   localparam int unsigned TpsWidth = $clog2(TICKS_PER_SECOND + 1);
   localparam logic [TpsWidth-1:0] TpsValue = TpsWidth'(TICKS_PER_SECOND);
   localparam int unsigned DivSteps = DATA_W;
   localparam int unsigned CntWidth = $clog2(DivSteps);
   localparam logic [CntWidth-1:0] CntLast = CntWidth'(DivSteps - 1);

   req_kind_type              type_ff, type_in;
   chan_type                  chan_ff, chan_in;
   logic [DATA_W-1:0]         ts_ff, ts_in;
   logic [DATA_W-1:0]         ovr_ff, ovr_in;
   logic [RES_W-1:0]          res_ff, res_in;
   logic [DATA_W-1:0]         last_left_ff, last_left_in;
   logic [DATA_W-1:0]         last_right_ff, last_right_in;
   logic [DATA_W-1:0]         freq_left_ff, freq_left_in;
   logic [DATA_W-1:0]         freq_right_ff, freq_right_in;
   logic [DATA_W-1:0]         period_ff, period_in;
   logic [DATA_W-1:0]         rem_ff, rem_in;
   logic [DATA_W-1:0]         quo_ff, quo_in;
   logic [CntWidth-1:0]       cnt_ff, cnt_in;
   logic [95:0]               rsp_data_ff, rsp_data_in;
   logic                      rsp_zero_ff, rsp_zero_in;

   logic [TpsWidth+RES_W-1:0] product;
   logic [DATA_W:0]           shifted;
   logic [DATA_W:0]           diff;
   logic                      ge;
   logic                      need_div;
   logic                      zero_period;
   logic [DATA_W-1:0]         quotient;
   logic [DATA_W-1:0]         live_val;

   assign need_div = ((type_ff == REQ_CAPTURE) || (type_ff == REQ_LIVE))
                     && ((chan_ff == CH_LEFT) || (chan_ff == CH_RIGHT));
   assign zero_period = need_div && (period_ff == '0);
   assign quotient = zero_period ? '1 : quo_ff;

   assign status.need_div = need_div;
   assign status.div_last = (cnt_ff == CntLast);

   assign product = TpsValue * res_ff;
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, period_ff};
   assign ge      = (shifted >= {1'b0, period_ff});

   assign rsp_tdata = rsp_data_ff;
   assign rsp_zero  = rsp_zero_ff;

   always_comb begin
      type_in = type_ff;
      chan_in = chan_ff;
      ts_in   = ts_ff;
      ovr_in  = ovr_ff;
      if (cmd.load) begin
         type_in = req_kind_type'(req_tuser[1:0]);
         chan_in = chan_type'(req_tuser[3:2]);
         ts_in   = req_tdata[31:0];
         ovr_in  = req_tdata[63:32];
      end
      res_in = csr_write ? csr_data : res_ff;
   end

   always_comb begin
      period_in = period_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      if (cmd.prep) begin
         period_in = ts_ff - ((chan_ff == CH_RIGHT) ? last_right_ff : last_left_ff);
         rem_in    = '0;
         quo_in    = DATA_W'(product);
         cnt_in    = '0;
      end else if (cmd.div_step) begin
         rem_in = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      freq_left_in  = freq_left_ff;
      freq_right_in = freq_right_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      live_val      = '0;
      case (type_ff)
         REQ_CAPTURE: begin
            if (chan_ff == CH_LEFT) begin
               freq_left_in = quotient;
               last_left_in = ts_ff;
            end else if (chan_ff == CH_RIGHT) begin
               freq_right_in = quotient;
               last_right_in = ts_ff;
            end
         end
         REQ_LIVE: begin
            if (need_div) begin
               live_val = quotient;
            end
         end
         REQ_OVERRIDE: begin
            if (chan_ff == CH_LEFT) begin
               freq_left_in = ovr_ff;
            end else if (chan_ff == CH_RIGHT) begin
               freq_right_in = ovr_ff;
            end
         end
         default: begin
            if (chan_ff inside {CH_LEFT, CH_BOTH}) begin
               freq_left_in = '0;
            end
            if (chan_ff inside {CH_RIGHT, CH_BOTH}) begin
               freq_right_in = '0;
            end
         end
      endcase
      rsp_data_in = {live_val, freq_right_in, freq_left_in};
      rsp_zero_in = zero_period;
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      chan_ff   <= chan_in;
      ts_ff     <= ts_in;
      ovr_ff    <= ovr_in;
      period_ff <= period_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_zero_ff <= rsp_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff        <= '0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         freq_left_ff  <= '0;
         freq_right_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         res_ff <= res_in;
         cnt_ff <= cnt_in;
         if (cmd.commit) begin
            last_left_ff  <= last_left_in;
            last_right_ff <= last_right_in;
            freq_left_ff  <= freq_left_in;
            freq_right_ff <= freq_right_in;
         end
      end
   end

endmodule

// File: rtl/core/two_channel_period_tachometer_top.sv
// Two-channel period tachometer. Each request beat on the req_ channel is a
// capture edge, a live query, a frequency override or a clear for the left or
// right sensor. A capture stores TICKS_PER_SECOND * resolution / period as the
// channel's frequency, where the period is the timestamp minus the channel's
// last edge modulo 2^32. A live query computes the same value without storing.
// Every request yields exactly one beat on the rsp_ channel carrying both
// stored frequencies and the live value; zero_period is set when the period
// was zero and the quotient was forced to all ones.
// The csr_ channel writes the 12-bit resolution and is always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Captures and live queries on a valid channel pass through a setup state,
// the radix-2 restoring divider and a commit state; all other requests go
// from the setup state straight to the commit state. The next request is
// taken in the cycle after the commit, so a new request is not taken while
// the previous one is still in flight.
// A finished response waits in an output register; the next request is taken
// while it waits, but its commit holds until rsp_tready frees the register.
// Reset clears the stored frequencies, the saved edges and the resolution.
module two_channel_period_tachometer_top
   import tach_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = 1000000
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,  // timestamp, override_value
   input  logic [3:0]        req_tuser,  // req_type, channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata,  // freq_left, freq_right, live_freq
   output logic              rsp_tuser,  // zero_period
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [RES_W-1:0]  csr_data
);

   tach_cmd_type    cmd;
   tach_status_type status;

   assign csr_ready = 1'b1;

   tach_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tach_dp #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_zero  (rsp_tuser)
   );

endmodule

// File: rtl/core/tach_chk.sv
module tach_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [95:0]       rsp_tdata,
   input logic              rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_zero_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[31:0] == 32'hFFFF_FFFF) || (rsp_tdata[63:32] == 32'hFFFF_FFFF)
         || (rsp_tdata[95:64] == 32'hFFFF_FFFF))
      else $error("zero period flagged without an all-ones quotient");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response beat right after reset");

endmodule

bind two_channel_period_tachometer_top tach_chk u_tach_chk (.*);

// File: tb/sv/tb_top.sv
module tb_top
   import tach_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TICKS_PER_SECOND = 1000000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] freq_left;
      logic [31:0] freq_right;
      logic [31:0] live_freq;
      logic        zero_period;
   } tach_reading_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [63:0]        req_tdata = '0;
   logic [3:0]         req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [95:0]        rsp_tdata;
   logic               rsp_tuser;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RES_W-1:0]   csr_data = '0;

   logic [RES_W-1:0]   mdl_res = '0;
   logic [31:0]        mdl_last_left = '0;
   logic [31:0]        mdl_last_right = '0;
   logic [31:0]        mdl_freq_left = '0;
   logic [31:0]        mdl_freq_right = '0;

   tach_reading_type   freq_reading_q[$];
   tach_reading_type   want;
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   int                 rx_hold_gen = 0;
   bit                 idle_enable = 1'b1;

   two_channel_period_tachometer_top #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] period_rate(input logic [31:0] now,
                                               input logic [31:0] prev,
                                               output logic zero);
      logic [31:0] period;
      logic [63:0] scaled;
      period = now - prev;
      scaled = 64'(TICKS_PER_SECOND) * 64'(mdl_res);
      zero = (period == 32'd0);
      if (zero) return '1;
      return 32'(scaled / 64'(period));
   endfunction

   function automatic tach_reading_type predict_reading(req_kind_type kind, chan_type chan,
                                                        logic [31:0] stamp, logic [31:0] ovr);
      tach_reading_type r;
      logic zero;
      r.live_freq = '0;
      zero = 1'b0;
      case (kind)
         REQ_CAPTURE: begin
            if (chan == CH_LEFT) begin
               mdl_freq_left = period_rate(stamp, mdl_last_left, zero);
               mdl_last_left = stamp;
            end else if (chan == CH_RIGHT) begin
               mdl_freq_right = period_rate(stamp, mdl_last_right, zero);
               mdl_last_right = stamp;
            end
         end
         REQ_LIVE: begin
            if (chan == CH_LEFT) r.live_freq = period_rate(stamp, mdl_last_left, zero);
            else if (chan == CH_RIGHT) r.live_freq = period_rate(stamp, mdl_last_right, zero);
         end
         REQ_OVERRIDE: begin
            if (chan == CH_LEFT) mdl_freq_left = ovr;
            else if (chan == CH_RIGHT) mdl_freq_right = ovr;
         end
         default: begin
            if (chan == CH_LEFT || chan == CH_BOTH) mdl_freq_left = '0;
            if (chan == CH_RIGHT || chan == CH_BOTH) mdl_freq_right = '0;
         end
      endcase
      r.freq_left = mdl_freq_left;
      r.freq_right = mdl_freq_right;
      r.zero_period = zero;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
      $display("MISMATCH %s at %0t: got %h, wanted %h", what, $time, got, wanted);
      error_count++;
   endtask

   task automatic send_request(req_kind_type kind, chan_type chan,
                               logic [31:0] stamp, logic [31:0] ovr);
      while (idle_enable && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ovr, stamp};
      req_tuser <= {chan, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      freq_reading_q.push_back(predict_reading(kind, chan, stamp, ovr));
   endtask

   task automatic wait_for_readings(int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (freq_reading_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_resolution(logic [RES_W-1:0] value);
      wait_for_readings(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mdl_res = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_stamp(logic [31:0] prev);
      int unsigned p;
      p = $urandom_range(99);
      if (p < 5) return prev;
      if (p < 35) return prev + $urandom_range(1, 1000);
      if (p < 65) return prev + $urandom_range(1000, 1000000);
      if (p < 85) return prev + $urandom;
      return $urandom;
   endfunction

   task automatic send_random_request();
      req_kind_type kind;
      chan_type chan;
      logic [31:0] stamp;
      logic [31:0] ovr;
      int unsigned p;
      p = $urandom_range(99);
      if (p < 45) kind = REQ_CAPTURE;
      else if (p < 70) kind = REQ_LIVE;
      else if (p < 85) kind = REQ_OVERRIDE;
      else kind = REQ_CLEAR;
      if (kind == REQ_CLEAR || $urandom_range(99) < 10) chan = chan_type'($urandom_range(3));
      else chan = ($urandom_range(1) == 0) ? CH_LEFT : CH_RIGHT;
      if (chan == CH_LEFT) stamp = pick_stamp(mdl_last_left);
      else if (chan == CH_RIGHT) stamp = pick_stamp(mdl_last_right);
      else stamp = $urandom;
      p = $urandom_range(99);
      if (p < 5) ovr = '0;
      else if (p < 10) ovr = '1;
      else ovr = $urandom;
      send_request(kind, chan, stamp, ovr);
   endtask

   task automatic test_directed_extremes();
      write_resolution(12'd4095);
      send_request(REQ_CAPTURE, CH_LEFT, 32'd0, 32'd0);
      send_request(REQ_CAPTURE, CH_LEFT, 32'd1, 32'd0);
      send_request(REQ_CAPTURE, CH_RIGHT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_CAPTURE, CH_RIGHT, 32'd0, 32'd0);
      send_request(REQ_LIVE, CH_LEFT, 32'd1, 32'd0);
      send_request(REQ_LIVE, CH_RIGHT, 32'd0, 32'd0);
      send_request(REQ_LIVE, CH_LEFT, 32'd1 + 32'd4095000000, 32'd0);
      send_request(REQ_LIVE, CH_RIGHT, 32'd4095000000, 32'd0);
      send_request(REQ_LIVE, CH_LEFT, 32'd0, 32'd0);
      send_request(REQ_LIVE, CH_NONE, 32'd5, 32'd0);
      send_request(REQ_LIVE, CH_BOTH, 32'd5, 32'd0);
      send_request(REQ_CAPTURE, CH_NONE, 32'd77, 32'd0);
      send_request(REQ_CAPTURE, CH_BOTH, 32'd77, 32'd0);
      send_request(REQ_OVERRIDE, CH_LEFT, 32'd0, 32'hFFFF_FFFF);
      send_request(REQ_OVERRIDE, CH_RIGHT, 32'd0, 32'h5A5A_A5A5);
      send_request(REQ_OVERRIDE, CH_NONE, 32'd0, 32'h1234_5678);
      send_request(REQ_OVERRIDE, CH_BOTH, 32'd0, 32'h8765_4321);
      send_request(REQ_CLEAR, CH_NONE, 32'd0, 32'd0);
      send_request(REQ_CLEAR, CH_LEFT, 32'd0, 32'd0);
      send_request(REQ_CLEAR, CH_RIGHT, 32'd0, 32'd0);
      send_request(REQ_OVERRIDE, CH_LEFT, 32'd0, 32'd1);
      send_request(REQ_OVERRIDE, CH_RIGHT, 32'd0, 32'd2);
      send_request(REQ_CLEAR, CH_BOTH, 32'd0, 32'd0);
      send_request(REQ_CAPTURE, CH_LEFT, 32'd1001, 32'd0);
   endtask

   task automatic test_resolution_phases();
      logic [RES_W-1:0] settings[5];
      settings[0] = '0;
      settings[1] = 12'd1;
      settings[2] = 12'd4095;
      settings[3] = RES_W'($urandom_range(2, 4094));
      settings[4] = RES_W'($urandom_range(2, 4094));
      foreach (settings[i]) begin
         write_resolution(settings[i]);
         repeat (280) send_random_request();
      end
   endtask

   task automatic test_output_backpressure();
      rx_hold_gen++;
      repeat (30) send_random_request();
      wait_for_readings(0);
   endtask

   task automatic test_sender_pause();
      repeat (12) send_random_request();
      wait_for_readings(0);
      repeat (12) send_random_request();
   endtask

   task automatic test_no_idle_stretch();
      idle_enable = 1'b0;
      repeat (150) send_random_request();
      wait_for_readings(0);
      idle_enable = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int seen_gen;
      int hold_left;
      seen_gen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_gen != seen_gen) begin
            seen_gen = rx_hold_gen;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= idle_enable ? ($urandom_range(99) >= 6) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (freq_reading_q.size() == 0) begin
            report_mismatch("response with nothing pending", rsp_tdata[31:0], 32'd0);
         end else begin
            want = freq_reading_q.pop_front();
            if (rsp_tdata[31:0] !== want.freq_left)
               report_mismatch("freq_left", rsp_tdata[31:0], want.freq_left);
            if (rsp_tdata[63:32] !== want.freq_right)
               report_mismatch("freq_right", rsp_tdata[63:32], want.freq_right);
            if (rsp_tdata[95:64] !== want.live_freq)
               report_mismatch("live_freq", rsp_tdata[95:64], want.live_freq);
            if (rsp_tuser !== want.zero_period)
               report_mismatch("zero_period", {31'd0, rsp_tuser}, {31'd0, want.zero_period});
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_resolution_phases();
      test_output_backpressure();
      test_sender_pause();
      test_no_idle_stretch();
      wait_for_readings(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/tach_pkg.sv
rtl/core/tach_ctrl.sv
rtl/core/tach_dp.sv
rtl/core/two_channel_period_tachometer_top.sv
rtl/core/tach_chk.sv
tb/sv/tb_top.sv
